>>> sv/assert_macros.svh
// assertion macros shared by the tumbling window statistics rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond holds in a cycle -> expr holds in the same cycle
`define ASSERT_IMPLIES(name, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed: same-cycle implication");

// cond holds in a cycle -> expr holds in the next cycle
`define ASSERT_NEXT(name, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> sv/twstat_pkg.sv
// shared types and constants of the tumbling window statistics block
package twstat_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int TIME_BITS   = 48;
    localparam int COUNT_BITS  = 32;
    localparam int SUM_BITS    = 64;
    localparam int LEN_BITS    = 32;
    localparam int AVG_BITS    = 32;

    localparam logic [LEN_BITS-1:0] WINDOW_LEN_RESET = LEN_BITS'(1000);

    // input request
    typedef struct packed {
        logic [TIME_BITS-1:0]          timestamp_ms;
        logic signed [SAMPLE_BITS-1:0] sample_value;
    } twstat_in_t;

    // result request
    typedef struct packed {
        logic                          window_ready;
        logic [COUNT_BITS-1:0]         sample_count;
        logic signed [AVG_BITS-1:0]    average;
        logic signed [SAMPLE_BITS-1:0] minimum;
        logic signed [SAMPLE_BITS-1:0] maximum;
    } twstat_out_t;

    // sequencer strobes into the accumulator
    typedef struct packed {
        logic update;
        logic check;
    } twstat_ctrl_t;

    // running window statistics
    typedef struct packed {
        logic                          window_done;
        logic [COUNT_BITS-1:0]         count;
        logic signed [SUM_BITS-1:0]    sum;
        logic signed [SAMPLE_BITS-1:0] min;
        logic signed [SAMPLE_BITS-1:0] max;
    } twstat_stats_t;

endpackage

>>> sv/twstat_divider.sv
// shared restoring divider: signed sum over unsigned count, saturated to 32 bits
module twstat_divider (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic signed [twstat_pkg::SUM_BITS-1:0]    dividend,
    input  logic [twstat_pkg::COUNT_BITS-1:0]         divisor,
    output logic                                      done,
    output logic signed [twstat_pkg::AVG_BITS-1:0]    quotient
);
    import twstat_pkg::*;

    `include "assert_macros.svh"

    localparam int HALF_BITS = SUM_BITS / 2;
    localparam int CNT_BITS  = $clog2(HALF_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(HALF_BITS - 1);
    localparam logic signed [AVG_BITS-1:0] AVG_MAX = {1'b0, {(AVG_BITS-1){1'b1}}};
    localparam logic signed [AVG_BITS-1:0] AVG_MIN = {1'b1, {(AVG_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        DV_IDLE = 4'b0001,
        DV_LOAD = 4'b0010,
        DV_ITER = 4'b0100,
        DV_DONE = 4'b1000
    } dv_state_t;

    dv_state_t             state_reg, state_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  neg_reg, neg_next;
    logic                  sat_reg, sat_next;
    logic [HALF_BITS-1:0]  rem_reg, rem_next;
    logic [HALF_BITS-1:0]  quo_reg, quo_next;
    logic [COUNT_BITS-1:0] divisor_reg, divisor_next;

    logic [SUM_BITS-1:0]   mag;
    logic [HALF_BITS:0]    trial;
    logic [HALF_BITS:0]    trial_diff;
    logic                  trial_ge;
    logic                  big;

    // magnitude of the dividend
    always_comb
    begin
        if (dividend[SUM_BITS-1])
            mag = ~dividend + 1'b1;
        else
            mag = dividend;
    end

    // one quotient bit per step
    always_comb
    begin
        trial      = {rem_reg, quo_reg[HALF_BITS-1]};
        trial_diff = trial - {{(HALF_BITS+1-COUNT_BITS){1'b0}}, divisor_reg};
        trial_ge   = trial >= {{(HALF_BITS+1-COUNT_BITS){1'b0}}, divisor_reg};
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        sat_next     = sat_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        unique case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    neg_next     = dividend[SUM_BITS-1];
                    rem_next     = mag[SUM_BITS-1:HALF_BITS];
                    quo_next     = mag[HALF_BITS-1:0];
                    divisor_next = divisor;
                    state_next   = DV_LOAD;
                end
            end
            DV_LOAD:
            begin
                // upper half not below the divisor means quotient past 32 bits
                sat_next = rem_reg >= HALF_BITS'(divisor_reg);
                cnt_next = '0;
                if (rem_reg >= HALF_BITS'(divisor_reg))
                    state_next = DV_DONE;
                else
                    state_next = DV_ITER;
            end
            DV_ITER:
            begin
                rem_next = trial_ge ? trial_diff[HALF_BITS-1:0] : trial[HALF_BITS-1:0];
                quo_next = {quo_reg[HALF_BITS-2:0], trial_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                    state_next = DV_DONE;
            end
            DV_DONE:
            begin
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sat_reg   <= sat_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        neg_reg     <= neg_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    // signed, saturated result
    always_comb
    begin
        big = sat_reg || quo_reg[HALF_BITS-1];
        if (big)
            quotient = neg_reg ? AVG_MIN : AVG_MAX;
        else if (neg_reg)
            quotient = AVG_BITS'(~quo_reg + 1'b1);
        else
            quotient = AVG_BITS'(quo_reg);
    end

    assign done = (state_reg == DV_DONE);

    `ASSERT_IMPLIES(a_start_when_idle, start, state_reg == DV_IDLE)
    `ASSERT_IMPLIES(a_divisor_nonzero, state_reg == DV_LOAD, divisor_reg != '0)
    `ASSERT_IMPLIES(a_rem_below_divisor, state_reg == DV_ITER,
                    rem_reg < HALF_BITS'(divisor_reg))

endmodule

>>> sv/twstat_accum.sv
// window state: start time, count, saturating sum, min, max and completion
module twstat_accum (
    input  logic                                clk,
    input  logic                                rst_n,
    input  twstat_pkg::twstat_ctrl_t            ctrl,
    input  twstat_pkg::twstat_in_t              sample,
    input  logic [twstat_pkg::LEN_BITS-1:0]     window_len,
    output twstat_pkg::twstat_stats_t           stats
);
    import twstat_pkg::*;

    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    logic [TIME_BITS-1:0]          start_reg, start_next;
    logic [COUNT_BITS-1:0]         count_reg, count_next;
    logic signed [SUM_BITS-1:0]    sum_reg, sum_next;
    logic signed [SAMPLE_BITS-1:0] min_reg, min_next;
    logic signed [SAMPLE_BITS-1:0] max_reg, max_next;
    logic                          has_reg, has_next;
    logic                          done_reg, done_next;

    logic signed [SAMPLE_BITS-1:0] sv;
    logic signed [SUM_BITS-1:0]    sv_ext;
    logic signed [SUM_BITS-1:0]    sum_add;
    logic                          sum_ovf;
    logic signed [SUM_BITS-1:0]    sum_sat;
    logic [TIME_BITS:0]            elapsed;
    logic                          reached;

    // saturating sum
    always_comb
    begin
        sv      = sample.sample_value;
        sv_ext  = {{(SUM_BITS-SAMPLE_BITS){sv[SAMPLE_BITS-1]}}, sv};
        sum_add = sum_reg + sv_ext;
        sum_ovf = (sum_reg[SUM_BITS-1] == sv_ext[SUM_BITS-1])
                  && (sum_add[SUM_BITS-1] != sum_reg[SUM_BITS-1]);
        if (sum_ovf)
            sum_sat = sum_reg[SUM_BITS-1] ? SUM_MIN : SUM_MAX;
        else
            sum_sat = sum_add;
    end

    // elapsed time since window start, borrow marks an earlier timestamp
    always_comb
    begin
        elapsed = {1'b0, sample.timestamp_ms} - {1'b0, start_reg};
        reached = !elapsed[TIME_BITS]
                  && (elapsed[TIME_BITS-1:0]
                      >= {{(TIME_BITS-LEN_BITS){1'b0}}, window_len});
    end

    // next state
    always_comb
    begin
        start_next = start_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        has_next   = has_reg;
        done_next  = done_reg;
        if (ctrl.update)
        begin
            if (done_reg || !has_reg)
            begin
                // fresh window: clear and take the first sample
                start_next = sample.timestamp_ms;
                count_next = COUNT_BITS'(1);
                sum_next   = sv_ext;
                min_next   = sv;
                max_next   = sv;
                has_next   = 1'b1;
            end
            else
            begin
                if (count_reg != '1)
                    count_next = count_reg + 1'b1;
                sum_next = sum_sat;
                if (sv > max_reg)
                    max_next = sv;
                if (sv < min_reg)
                    min_next = sv;
            end
        end
        if (ctrl.check)
            done_next = reached;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
            has_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            start_reg <= start_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            has_reg   <= has_next;
            done_reg  <= done_next;
        end
    end

    assign stats.window_done = done_reg;
    assign stats.count       = count_reg;
    assign stats.sum         = sum_reg;
    assign stats.min         = min_reg;
    assign stats.max         = max_reg;

endmodule

>>> sv/tumbling_window_stats.sv
// top level: sequencer, config register and result register of the window statistics
//
//  channel   direction  handshake              payload
//  sample    in         sample_valid/stall     twstat_in_t  (timestamp, Q16.16 value)
//  result    out        result_valid/stall     twstat_out_t (ready, count, avg, min, max)
//  cfg       in         cfg_valid/cfg_ready    window length in ms
//
// a request runs from acceptance to its result through an update, a window check that
// also starts the divider, a divider setup step, 32 restoring-division steps for the
// average (skipped when the quotient saturates), a done step and an output load; the
// next request is taken the cycle after the result register is loaded. reset clears
// all window state, the window length returns to 1000 ms. a stalled result holds the
// last step until the register frees.
module tumbling_window_stats (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  twstat_pkg::twstat_in_t              sample,
    output logic                                result_valid,
    input  logic                                result_stall,
    output twstat_pkg::twstat_out_t             result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [twstat_pkg::LEN_BITS-1:0]     cfg_data
);
    import twstat_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UPDATE = 5'b00010,
        ST_CHECK  = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_OUT    = 5'b10000
    } st_state_t;

    st_state_t             state_reg, state_next;
    logic [LEN_BITS-1:0]   window_len_reg, window_len_next;
    twstat_in_t            sample_reg, sample_next;
    logic                  result_valid_reg, result_valid_next;
    twstat_out_t           result_reg, result_next;

    twstat_ctrl_t          ctrl;
    twstat_stats_t         stats;
    logic                  div_start;
    logic                  div_done;
    logic signed [AVG_BITS-1:0] div_quotient;
    logic                  accept;
    logic                  out_free;

    // handshakes
    assign sample_stall = (state_reg != ST_IDLE);
    assign accept       = sample_valid && !sample_stall;
    assign cfg_ready    = 1'b1;
    assign out_free     = !result_valid_reg || !result_stall;

    // accumulator and shared divider
    twstat_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .sample     (sample_reg),
        .window_len (window_len_reg),
        .stats      (stats)
    );

    twstat_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (stats.sum),
        .divisor  (stats.count),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        sample_next       = sample_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        ctrl.update       = 1'b0;
        ctrl.check        = 1'b0;
        div_start         = 1'b0;

        if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sample_next = sample;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                ctrl.update = 1'b1;
                state_next  = ST_CHECK;
            end
            ST_CHECK:
            begin
                ctrl.check = 1'b1;
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    result_next.window_ready = stats.window_done;
                    result_next.sample_count = stats.count;
                    result_next.average      = div_quotient;
                    result_next.minimum      = stats.min;
                    result_next.maximum      = stats.max;
                    result_valid_next        = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // config register
    always_comb
    begin
        window_len_next = window_len_reg;
        if (cfg_valid && cfg_ready)
            window_len_next = cfg_data;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            window_len_reg   <= WINDOW_LEN_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            window_len_reg   <= window_len_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_IMPLIES(a_div_done_while_waiting, div_done, state_reg == ST_DIV)
    `ASSERT_IMPLIES(a_div_count_nonzero, div_start, stats.count != '0)
    `ASSERT_NEXT(a_result_loaded, (state_reg == ST_OUT) && out_free,
                 result_valid && (state_reg == ST_IDLE))

endmodule
